/* rtl/core/smi_pkg.sv */
// Shared types and constants of the motor drive safety interlock.
`default_nettype none
package smi_pkg;

	localparam int unsigned CmpW   = 16;
	localparam int unsigned KeyW   = 32;
	localparam int unsigned SeqW   = 32;
	localparam int unsigned BeatW  = 32;
	localparam int unsigned CodeW  = 4;
	localparam int unsigned IdxW   = 2;
	localparam int unsigned WrW    = 32;
	localparam int unsigned InDatW  = 136;
	localparam int unsigned OutDatW = 40;

	localparam logic [IdxW-1:0] REG_MAX_COMPARE   = 2'd0;
	localparam logic [IdxW-1:0] REG_ARM_KEY       = 2'd1;
	localparam logic [IdxW-1:0] REG_CLEAR_KEY     = 2'd2;
	localparam logic [IdxW-1:0] REG_SERVICE_READY = 2'd3;

	typedef enum logic [CodeW-1:0] {
		REQ_SET_DRIVE  = 4'd0,
		REQ_ARM        = 4'd1,
		REQ_DISARM     = 4'd2,
		REQ_CLEAR      = 4'd3,
		REQ_KICK       = 4'd4,
		REQ_ESTOP_RISE = 4'd5,
		REQ_ESTOP_FALL = 4'd6,
		REQ_INT_FAULT  = 4'd7,
		REQ_VIOLATION  = 4'd8,
		REQ_STATUS     = 4'd9
	} req_kind_t;

	typedef enum logic [CodeW-1:0] {
		RC_OK        = 4'd0,
		RC_BAD_ARG   = 4'd1,
		RC_RANGE     = 4'd2,
		RC_DIRECTION = 4'd3,
		RC_ESTOP     = 4'd4,
		RC_FAULT     = 4'd5,
		RC_NOT_ARMED = 4'd6,
		RC_STALE     = 4'd7,
		RC_NOT_READY = 4'd8,
		RC_INTERNAL  = 4'd9
	} rc_t;

	typedef struct packed {
		logic [CodeW-1:0] kind;
		logic             estop_level;
		logic [KeyW-1:0]  token;
		logic [CmpW-1:0]  forward_value;
		logic [CmpW-1:0]  reverse_value;
		logic [SeqW-1:0]  cmd_seq;
		logic [BeatW-1:0] beat;
	} req_item_t;

	typedef struct packed {
		logic [CmpW-1:0] max_compare;
		logic [KeyW-1:0] arm_key;
		logic [KeyW-1:0] clear_key;
		logic            service_ready;
	} cfg_t;

	typedef struct packed {
		logic             fault;
		logic             estop;
		logic             armed;
		logic             internal_err;
		logic             violation;
		logic [CmpW-1:0]  fwd;
		logic [CmpW-1:0]  rev;
		logic [SeqW-1:0]  last_seq;
		logic             seq_known;
		logic [BeatW-1:0] last_beat;
	} state_t;

	localparam state_t STATE_RESET = '{
		fault:        1'b0,
		estop:        1'b0,
		armed:        1'b0,
		internal_err: 1'b0,
		violation:    1'b0,
		fwd:          '0,
		rev:          '0,
		last_seq:     '0,
		seq_known:    1'b0,
		last_beat:    '1
	};

	typedef struct packed {
		rc_t             code;
		logic            fault;
		logic            estop;
		logic            armed;
		logic            internal_err;
		logic            violation;
		logic            ready;
		logic [CmpW-1:0] fwd;
		logic [CmpW-1:0] rev;
		logic            refresh;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/smi_cfg.sv */
// Configuration register file of the motor drive safety interlock.
`default_nettype none
module smi_cfg (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [smi_pkg::IdxW-1:0] wr_index,
	input  wire logic [smi_pkg::WrW-1:0]  wr_data,
	output smi_pkg::cfg_t                 cfg
);

	smi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				smi_pkg::REG_MAX_COMPARE: begin
					cfg_q.max_compare <= wr_data[smi_pkg::CmpW-1:0];
				end
				smi_pkg::REG_ARM_KEY: begin
					cfg_q.arm_key <= wr_data[smi_pkg::KeyW-1:0];
				end
				smi_pkg::REG_CLEAR_KEY: begin
					cfg_q.clear_key <= wr_data[smi_pkg::KeyW-1:0];
				end
				smi_pkg::REG_SERVICE_READY: begin
					cfg_q.service_ready <= wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/smi_decide.sv */
// Single-pass decision logic: checks one request against state and configuration.
`default_nettype none
module smi_decide (
	input  wire smi_pkg::req_item_t req,
	input  wire smi_pkg::state_t    st,
	input  wire smi_pkg::cfg_t      cfg,
	output smi_pkg::state_t         nxt,
	output smi_pkg::result_t        res
);

	logic [smi_pkg::SeqW-1:0] diff;
	logic                     stale;
	smi_pkg::rc_t             code;
	logic                     refresh;

	assign diff  = req.cmd_seq - st.last_seq;
	assign stale = st.seq_known && ((diff == '0) || diff[smi_pkg::SeqW-1]);

	always_comb begin
		nxt     = st;
		code    = smi_pkg::RC_OK;
		refresh = 1'b0;
		case (smi_pkg::req_kind_t'(req.kind))
			smi_pkg::REQ_SET_DRIVE: begin
				if (req.forward_value > cfg.max_compare ||
				    req.reverse_value > cfg.max_compare) begin
					code = smi_pkg::RC_RANGE;
				end else if (req.forward_value != '0 && req.reverse_value != '0) begin
					code = smi_pkg::RC_DIRECTION;
				end else if (req.estop_level) begin
					nxt.estop = 1'b1;
					nxt.fault = 1'b1;
					nxt.fwd   = '0;
					nxt.rev   = '0;
					nxt.armed = 1'b0;
					code      = smi_pkg::RC_ESTOP;
				end else if (st.fault) begin
					code = smi_pkg::RC_FAULT;
				end else if (!st.armed) begin
					code = smi_pkg::RC_NOT_ARMED;
				end else if (stale) begin
					code = smi_pkg::RC_STALE;
				end else begin
					nxt.fwd       = req.forward_value;
					nxt.rev       = req.reverse_value;
					nxt.last_seq  = req.cmd_seq;
					nxt.seq_known = 1'b1;
				end
			end
			smi_pkg::REQ_ARM: begin
				if (req.token != cfg.arm_key) begin
					code = smi_pkg::RC_BAD_ARG;
				end else if (!cfg.service_ready) begin
					code = smi_pkg::RC_NOT_READY;
				end else if (req.estop_level) begin
					nxt.estop = 1'b1;
					nxt.fault = 1'b1;
					nxt.fwd   = '0;
					nxt.rev   = '0;
					nxt.armed = 1'b0;
					code      = smi_pkg::RC_ESTOP;
				end else if (st.fault) begin
					code = smi_pkg::RC_FAULT;
				end else begin
					nxt.fwd       = '0;
					nxt.rev       = '0;
					nxt.armed     = 1'b1;
					nxt.seq_known = 1'b0;
				end
			end
			smi_pkg::REQ_DISARM: begin
				nxt.fwd       = '0;
				nxt.rev       = '0;
				nxt.armed     = 1'b0;
				nxt.seq_known = 1'b0;
			end
			smi_pkg::REQ_CLEAR: begin
				if (req.token != cfg.clear_key) begin
					code = smi_pkg::RC_BAD_ARG;
				end else if (req.estop_level) begin
					nxt.estop = 1'b1;
					nxt.fault = 1'b1;
					nxt.fwd   = '0;
					nxt.rev   = '0;
					nxt.armed = 1'b0;
					code      = smi_pkg::RC_ESTOP;
				end else if (st.internal_err || st.violation) begin
					code = smi_pkg::RC_INTERNAL;
				end else begin
					nxt.fwd       = '0;
					nxt.rev       = '0;
					nxt.armed     = 1'b0;
					nxt.estop     = 1'b0;
					nxt.fault     = 1'b0;
					nxt.seq_known = 1'b0;
				end
			end
			smi_pkg::REQ_KICK: begin
				if (!cfg.service_ready) begin
					code = smi_pkg::RC_NOT_READY;
				end else if (req.beat == st.last_beat) begin
					code = smi_pkg::RC_STALE;
				end else begin
					nxt.last_beat = req.beat;
					refresh       = 1'b1;
				end
			end
			smi_pkg::REQ_ESTOP_RISE: begin
				nxt.estop = 1'b1;
				nxt.fault = 1'b1;
				nxt.fwd   = '0;
				nxt.rev   = '0;
				nxt.armed = 1'b0;
			end
			smi_pkg::REQ_ESTOP_FALL: begin
				nxt.estop = 1'b0;
			end
			smi_pkg::REQ_INT_FAULT: begin
				nxt.internal_err = 1'b1;
				nxt.fault        = 1'b1;
				nxt.fwd          = '0;
				nxt.rev          = '0;
				nxt.armed        = 1'b0;
			end
			smi_pkg::REQ_VIOLATION: begin
				nxt.violation = 1'b1;
				nxt.fault     = 1'b1;
				nxt.fwd       = '0;
				nxt.rev       = '0;
				nxt.armed     = 1'b0;
			end
			smi_pkg::REQ_STATUS: begin
				if (req.estop_level) begin
					nxt.estop = 1'b1;
					nxt.fault = 1'b1;
					nxt.fwd   = '0;
					nxt.rev   = '0;
					nxt.armed = 1'b0;
				end else begin
					nxt.estop = 1'b0;
				end
			end
			default: begin
				code = smi_pkg::RC_BAD_ARG;
			end
		endcase
	end

	assign res.code         = code;
	assign res.fault        = nxt.fault;
	assign res.estop        = nxt.estop;
	assign res.armed        = nxt.armed;
	assign res.internal_err = nxt.internal_err;
	assign res.violation    = nxt.violation;
	assign res.ready        = cfg.service_ready;
	assign res.fwd          = nxt.fwd;
	assign res.rev          = nxt.rev;
	assign res.refresh      = refresh;

endmodule
`default_nettype wire

/* rtl/core/motor_drive_safety_interlock.sv */
// Top level of the motor drive safety interlock: input register, state and result register.
//
// Each request is captured in an input register, checked in one pass against the
// interlock state and configuration, and its status is then held in a result
// register. One request per cycle is taken as long as the result side keeps up;
// the state update happens at the same edge as the result capture, so the next
// request always sees the state left by the previous one. A stalled result
// register holds the input register, which then fills before the slave side stops
// accepting. Configuration must only be written while no request is in flight.
`default_nettype none
module motor_drive_safety_interlock (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Request channel.
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// estop_level, token, forward_value, reverse_value, cmd_seq, beat (low to high).
	input  wire logic [smi_pkg::InDatW-1:0]  s_tdata,
	// req_type.
	input  wire logic [smi_pkg::CodeW-1:0]   s_tuser,
	// Status channel.
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// fault_flag, estop_flag, armed_flag, internal_flag, violation_flag, ready_flag,
	// forward_drive, reverse_drive, dog_refresh (low to high).
	output logic [smi_pkg::OutDatW-1:0]      m_tdata,
	// result_code.
	output logic [smi_pkg::CodeW-1:0]        m_tuser,
	// Configuration write port.
	input  wire logic                        wr_en,
	input  wire logic [smi_pkg::IdxW-1:0]    wr_index,
	input  wire logic [smi_pkg::WrW-1:0]     wr_data
);

	smi_pkg::cfg_t      cfg;
	smi_pkg::req_item_t req_in;
	smi_pkg::req_item_t req_s1;
	logic               vld_s1;
	logic               adv;
	smi_pkg::state_t    state_q;
	smi_pkg::state_t    state_nxt;
	smi_pkg::result_t   res;
	smi_pkg::result_t   res_q;
	logic               out_vld_q;

	smi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign req_in.kind          = s_tuser;
	assign req_in.estop_level   = s_tdata[0];
	assign req_in.token         = s_tdata[32:1];
	assign req_in.forward_value = s_tdata[48:33];
	assign req_in.reverse_value = s_tdata[64:49];
	assign req_in.cmd_seq       = s_tdata[96:65];
	assign req_in.beat          = s_tdata[128:97];

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_in;
		end
	end

	smi_decide u_decide (
		.req (req_s1),
		.st  (state_q),
		.cfg (cfg),
		.nxt (state_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smi_pkg::STATE_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = res_q.code;
	assign m_tdata  = {1'b0, res_q.refresh, res_q.rev, res_q.fwd, res_q.ready,
	                   res_q.violation, res_q.internal_err, res_q.armed,
	                   res_q.estop, res_q.fault};

	// The outputs are never armed while a fault is latched.
	a_armed_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.armed |-> !state_q.fault)
		else $error("armed with a latched fault");

	// A non-zero drive is only applied while armed, and never in both directions.
	a_drive_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.fwd != '0 || state_q.rev != '0) |->
		(state_q.armed && (state_q.fwd == '0 || state_q.rev == '0)))
		else $error("drive applied while disarmed or in both directions");

	// A recorded internal error or violation keeps the fault latched.
	a_sticky_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.internal_err || state_q.violation) |-> state_q.fault)
		else $error("error recorded without a latched fault");

	// A watchdog refresh is only reported with an ok status.
	a_refresh_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && res_q.refresh) |-> (res_q.code == smi_pkg::RC_OK))
		else $error("refresh reported with an error status");

endmodule
`default_nettype wire
